>>> rtl/macd_pkg.sv
package macd_pkg;

  localparam int unsigned WORD_W = 16;

  // Displacement tables, indexed by a copy nibble.
  localparam logic [2:0] STEP_X [16] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd0, 3'd1, 3'd0, 3'd1,
                                         3'd2, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd0};
  localparam logic [4:0] STEP_Y [16] = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd2,
                                         5'd2, 5'd4, 5'd4, 5'd4, 5'd8, 5'd8, 5'd8, 5'd16};

  localparam logic [7:0] HI_MASK = 8'hf0;
  localparam logic [7:0] LO_MASK = 8'h0f;

  localparam logic CFG_CELLS = 1'b0;
  localparam logic CFG_ROWS  = 1'b1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WORD0,
    BK_WORD1
  } bk_state_t;

  // Classified cell passed from front to back.
  typedef struct packed {
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [15:0] lit0;
    logic [15:0] lit1;
    logic        clear;
    logic        last;
  } cell_t;

  // Result item.
  typedef struct packed {
    logic [15:0] word_high_nibble;
    logic [15:0] word_low_nibble;
    logic [1:0]  literals_used;
    logic        before_start;
    logic        end_of_image;
  } res_t;

endpackage

>>> rtl/macd_in_if.sv
interface macd_in_if;
  logic        valid;
  logic        ready;
  logic        start_image;
  logic        flag_a_next;
  logic [7:0]  flag_b_byte;
  logic [15:0] literal_first;
  logic [15:0] literal_second;

  modport source (output valid, start_image, flag_a_next, flag_b_byte, literal_first,
                  literal_second, input ready);
  modport sink   (input valid, start_image, flag_a_next, flag_b_byte, literal_first,
                  literal_second, output ready);
endinterface

>>> rtl/macd_out_if.sv
interface macd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_high_nibble;
  logic [15:0] word_low_nibble;
  logic [1:0]  literals_used;
  logic        before_start;
  logic        end_of_image;

  modport source (output valid, word_high_nibble, word_low_nibble, literals_used,
                  before_start, end_of_image, input ready);
  modport sink   (input valid, word_high_nibble, word_low_nibble, literals_used,
                  before_start, end_of_image, output ready);
endinterface

>>> rtl/macd_front.sv
module macd_front #(
  parameter int unsigned MAX_CELLS_PER_ROW = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 start_image,
  input  logic                 flag_a_next,
  input  logic [7:0]           flag_b_byte,
  input  logic [15:0]          literal_first,
  input  logic [15:0]          literal_second,
  input  logic [$clog2(MAX_CELLS_PER_ROW+1)-1:0] cpr,
  input  logic [12:0]          rows,
  output logic                 q_valid,
  input  logic                 q_ready,
  output macd_pkg::cell_t      q_cell
);
  localparam int COL_W = (MAX_CELLS_PER_ROW > 1) ? $clog2(MAX_CELLS_PER_ROW) : 1;
  localparam int CPR_W = $clog2(MAX_CELLS_PER_ROW + 1);

  logic [7:0]       act_mem [MAX_CELLS_PER_ROW];
  logic [MAX_CELLS_PER_ROW-1:0] act_vld_r, act_vld_nxt;
  logic [CPR_W-1:0] col_r, col_nxt;
  logic [11:0]      row_r, row_nxt;
  logic [COL_W-1:0] idx, nidx;
  logic [7:0]       act_old, act, act_pf_r;
  logic             clr, last, row_end, acc;
  logic [12:0]      row_p1;
  logic [CPR_W:0]   col_p1;

  assign in_ready = q_ready;
  assign acc      = in_valid && q_ready;
  assign clr      = start_image;
  assign idx      = clr ? '0 : col_r[COL_W-1:0];
  assign nidx     = col_nxt[COL_W-1:0];
  assign act_old  = (act_vld_r[idx] && !clr) ? act_pf_r : 8'd0;
  assign act      = flag_a_next ? (act_old ^ flag_b_byte) : act_old;
  assign col_p1   = clr ? (CPR_W+1)'(1) : ({1'b0, col_r} + (CPR_W+1)'(1));
  assign row_p1   = clr ? 13'd1 : ({1'b0, row_r} + 13'd1);
  assign row_end  = col_p1 >= {1'b0, cpr};
  assign last     = row_end && (row_p1 >= rows);

  always_comb begin
    act_vld_nxt = clr ? '0 : act_vld_r;
    act_vld_nxt[idx] = 1'b1;
    col_nxt = clr ? '0 : col_r;
    row_nxt = clr ? '0 : row_r;
    if (last) begin
      act_vld_nxt = '0;
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_p1[11:0];
    end else begin
      col_nxt = col_p1[CPR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_vld_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      act_vld_r <= act_vld_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Keep the action byte of the next column ready; forward it when just written.
  always_ff @(posedge clk) begin
    if (acc) begin
      act_mem[idx] <= act;
      act_pf_r <= (nidx == idx) ? act : act_mem[nidx];
    end
  end

  assign q_valid = in_valid;
  always_comb begin
    q_cell.hi    = 4'((act & macd_pkg::HI_MASK) >> 4);
    q_cell.lo    = 4'(act & macd_pkg::LO_MASK);
    q_cell.lit0  = literal_first;
    q_cell.lit1  = literal_second;
    q_cell.clear = clr;
    q_cell.last  = last;
  end
endmodule

>>> rtl/macd_queue.sv
module macd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  macd_pkg::cell_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output macd_pkg::cell_t rd_data
);
  macd_pkg::cell_t mem_r [2];
  logic [1:0] wp_r, rp_r;
  logic       wr_en, rd_en;

  assign wr_ready = (wp_r - rp_r) != 2'd2;
  assign rd_valid = wp_r != rp_r;
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r[0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r[0]] <= wr_data;
  end
endmodule

>>> rtl/macd_back.sv
module macd_back #(
  parameter int unsigned MAX_CELLS_PER_ROW = 256,
  parameter int unsigned HISTORY_ROWS      = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  macd_pkg::cell_t q_cell,
  input  logic [$clog2(MAX_CELLS_PER_ROW+1)-1:0] cpr,
  output logic            r_valid,
  input  logic            r_ready,
  output macd_pkg::res_t  r_data
);
  localparam int unsigned RING = HISTORY_ROWS * MAX_CELLS_PER_ROW * 2;
  localparam int AW    = $clog2(RING);
  localparam int FW    = $clog2(RING + 1);
  localparam int CPR_W = $clog2(MAX_CELLS_PER_ROW + 1);
  localparam int BW    = CPR_W + 7;

  logic [15:0] hist [RING];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  macd_pkg::bk_state_t st_r, st_nxt;
  macd_pkg::cell_t cell_r;
  logic [1:0]  used_r;
  logic        early_r;
  logic [15:0] w0_r, rd_r;
  logic        rd_zero_r, rd_lit_r;
  logic [15:0] rd_lit_val_r;
  logic        outv_r, outv_nxt;
  macd_pkg::res_t out_r;

  // stage control
  logic        take, step1, done, fire_out;
  logic [3:0]  code;
  logic [FW-1:0] fill_use, fill_inc;
  logic [BW-1:0] back;
  logic        early_now;
  logic [AW-1:0] raddr, base, back_a, wp_inc;
  logic [15:0] cur_word;

  assign fire_out = outv_r && r_ready;
  assign q_ready  = (st_r == macd_pkg::BK_IDLE) || (st_r == macd_pkg::BK_WORD1 && done);
  assign take     = q_valid && q_ready;

  // Read issue. A cell taken while the previous low word is being written
  // looks back from the slot after that word.
  always_comb begin
    wp_inc   = (wp_r == AW'(RING - 1)) ? '0 : wp_r + AW'(1);
    fill_inc = (fill_r == FW'(RING)) ? fill_r : fill_r + FW'(1);
    code = take ? q_cell.hi : cell_r.lo;
    if (take && st_r == macd_pkg::BK_IDLE) begin
      base = wp_r;
      fill_use = q_cell.clear ? '0 : fill_r;
    end else if (take) begin
      base = wp_inc;
      fill_use = (q_cell.clear || cell_r.last) ? '0 : fill_inc;
    end else begin
      base = wp_inc;
      fill_use = fill_inc;
    end
    back = BW'(macd_pkg::STEP_Y[code]) * BW'(cpr) * BW'(2) + BW'(macd_pkg::STEP_X[code]);
    early_now = BW'(back) > BW'(fill_use);
    back_a = AW'(back);
    raddr = (base >= back_a) ? base - back_a : base + AW'(RING) - back_a;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      macd_pkg::BK_IDLE:  if (take) st_nxt = macd_pkg::BK_WORD0;
      macd_pkg::BK_WORD0: st_nxt = macd_pkg::BK_WORD1;
      macd_pkg::BK_WORD1: if (done) st_nxt = take ? macd_pkg::BK_WORD0 : macd_pkg::BK_IDLE;
      default:            st_nxt = macd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    outv_nxt = outv_r;
    if (fire_out) outv_nxt = 1'b0;
    if (step1) begin
      wp_nxt = wp_inc;
      fill_nxt = fill_inc;
    end
    if (done) begin
      outv_nxt = 1'b1;
      wp_nxt = wp_inc;
      fill_nxt = cell_r.last ? '0 : fill_inc;
    end
    if (take && q_cell.clear) fill_nxt = '0;
  end

  assign cur_word = rd_lit_r ? rd_lit_val_r : (rd_zero_r ? 16'd0 : rd_r);
  assign step1    = st_r == macd_pkg::BK_WORD0;
  assign done     = (st_r == macd_pkg::BK_WORD1) && (!outv_r || r_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= macd_pkg::BK_IDLE;
      wp_r <= '0;
      fill_r <= '0;
      outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      wp_r <= wp_nxt;
      fill_r <= fill_nxt;
      outv_r <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cell_r <= q_cell;
      rd_r <= (st_r == macd_pkg::BK_WORD1 && back == BW'(1)) ? cur_word : hist[raddr];
      rd_lit_r <= q_cell.hi == 4'd0;
      rd_lit_val_r <= q_cell.lit0;
      rd_zero_r <= early_now;
      early_r <= (q_cell.hi != 4'd0) && early_now;
      used_r <= {1'b0, q_cell.hi == 4'd0};
    end
    if (step1) begin
      hist[wp_r] <= cur_word;
      w0_r <= cur_word;
      if (cell_r.lo == 4'd0) begin
        rd_lit_r <= 1'b1;
        rd_lit_val_r <= (used_r != 2'd0) ? cell_r.lit1 : cell_r.lit0;
        used_r <= used_r + 2'd1;
      end else begin
        rd_lit_r <= 1'b0;
        rd_zero_r <= early_now;
        early_r <= early_r || early_now;
        rd_r <= (back == BW'(1)) ? cur_word : hist[raddr];
      end
    end
    if (done) begin
      hist[wp_r] <= cur_word;
      out_r.word_high_nibble <= w0_r;
      out_r.word_low_nibble <= cur_word;
      out_r.literals_used <= used_r;
      out_r.before_start <= early_r;
      out_r.end_of_image <= cell_r.last;
    end
  end

  assign r_valid = outv_r;
  assign r_data  = out_r;

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FW'(RING))
    else $error("history fill over ring size");
  a_w0_w1: assert property (@(posedge clk) disable iff (!rst_n) step1 |=> st_r == macd_pkg::BK_WORD1)
    else $error("word1 must follow word0");
  a_take: assert property (@(posedge clk) disable iff (!rst_n) take |=> step1)
    else $error("accepted cell did not start");
endmodule

>>> rtl/mag_action_copy_decoder.sv
// Path: the two-entry queue, then the back's WORD0 and WORD1 states and output register.
// The back takes a new item when idle or as the last one finishes; the history memory,
//   read once per word with the low word able to copy the high word, sets the pace.
// Reset: rst_n synchronous active low; clears positions, action valid bits,
//   history fill count, queue and output valid. Configuration registers reset to 1.
module mag_action_copy_decoder #(
  parameter int unsigned MAX_CELLS_PER_ROW = 256,
  parameter int unsigned HISTORY_ROWS      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  macd_in_if.sink     in_ch,
  macd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);
  localparam int CPR_W = $clog2(MAX_CELLS_PER_ROW + 1);

  // Configuration registers, saturated copies used by the datapath.
  logic [8:0]  cells_r;
  logic [12:0] rows_r;
  logic [CPR_W-1:0] cpr;
  logic [12:0] rows;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= 9'd1;
      rows_r <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        macd_pkg::CFG_CELLS: cells_r <= cfg_wdata[8:0];
        macd_pkg::CFG_ROWS:  rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cells_r == 9'd0) cpr = CPR_W'(1);
    else if (32'(cells_r) > MAX_CELLS_PER_ROW) cpr = CPR_W'(MAX_CELLS_PER_ROW);
    else cpr = CPR_W'(cells_r);
    if (rows_r == 13'd0) rows = 13'd1;
    else if (rows_r > 13'd4096) rows = 13'd4096;
    else rows = rows_r;
  end

  // Front: track column/row, update action byte, classify the cell.
  logic            f_valid, f_ready;
  macd_pkg::cell_t f_cell;
  logic            b_valid, b_ready;
  macd_pkg::cell_t b_cell;

  macd_front #(.MAX_CELLS_PER_ROW(MAX_CELLS_PER_ROW)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .start_image(in_ch.start_image), .flag_a_next(in_ch.flag_a_next),
    .flag_b_byte(in_ch.flag_b_byte), .literal_first(in_ch.literal_first),
    .literal_second(in_ch.literal_second),
    .cpr, .rows,
    .q_valid(f_valid), .q_ready(f_ready), .q_cell(f_cell)
  );

  // Two-entry queue decouples classification from the history work.
  macd_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cell),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cell)
  );

  macd_pkg::res_t res;

  // Back: two words per cell, each copied from history or a literal and written to history; then hold the result.
  macd_back #(.MAX_CELLS_PER_ROW(MAX_CELLS_PER_ROW), .HISTORY_ROWS(HISTORY_ROWS)) u_back (
    .clk, .rst_n,
    .q_valid(b_valid), .q_ready(b_ready), .q_cell(b_cell),
    .cpr,
    .r_valid(out_ch.valid), .r_ready(out_ch.ready), .r_data(res)
  );

  assign out_ch.word_high_nibble = res.word_high_nibble;
  assign out_ch.word_low_nibble  = res.word_low_nibble;
  assign out_ch.literals_used    = res.literals_used;
  assign out_ch.before_start     = res.before_start;
  assign out_ch.end_of_image     = res.end_of_image;
endmodule
